@@ hw/rtl/fcb_pkg.sv @@
// Shared types and command codes for the camera basis unit.
// No dependencies; used by every module of the block but the sine table.
package fcb_pkg;

  typedef enum logic [1:0] {
    CMD_SET_POS = 2'd0,
    CMD_MOVE    = 2'd1,
    CMD_ROTATE  = 2'd2,
    CMD_SET_ANG = 2'd3
  } cmd_t;

  // Camera state as held by the first stage.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [15:0] yaw;
    logic signed [15:0] pitch;
  } cam_state_t;

  // Second stage: position plus the quadrants that steer the table data.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [1:0]  yaw_q;
    logic        [1:0]  pitch_q;
  } stage2_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] look_x;
    logic signed [15:0] look_y;
    logic signed [15:0] look_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } result_t;

endpackage

@@ hw/rtl/fcb_sine_rom.sv @@
// Quarter-wave sine table with two registered read ports.
// Reads T[i] and T[N-i] for the index taken from one binary angle; no package use.
module fcb_sine_rom #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] angle,
  output logic [14:0] lo,
  output logic [14:0] hi
);

  localparam int TabN  = 1 << SINE_TABLE_BITS;
  localparam int AddrW = SINE_TABLE_BITS + 1;
  localparam logic [AddrW-1:0] TabTop = AddrW'(TabN);

  // Fixed-point Taylor series in Q2.30, seven terms past x, rounded to Q1.14.
  function automatic logic [14:0] sine_entry(input int unsigned i);
    logic        [63:0] x;
    logic        [63:0] x2;
    logic        [63:0] term;
    logic signed [63:0] sum;
    logic        [63:0] v;
    x    = (64'd1686629713 * 64'(i) + 64'(TabN / 2)) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
    if (sum < 0) sum = 0;
    v = ($unsigned(sum) + 64'd32768) >> 16;
    if (v > 64'd16384) v = 64'd16384;
    if (i == 0) v = 64'd0;
    if (i == TabN) v = 64'd16384;
    return v[14:0];
  endfunction

  logic [14:0]      tab [TabN+1];
  logic [AddrW-1:0] idx;
  logic [AddrW-1:0] idx_mirror;

  for (genvar g = 0; g <= TabN; g++) begin : g_tab
    assign tab[g] = sine_entry(g);
  end

  assign idx        = {1'b0, angle[13 -: SINE_TABLE_BITS]};
  assign idx_mirror = TabTop - idx;

  always_ff @(posedge clk) begin
    if (en) begin
      lo <= tab[idx];
      hi <= tab[idx_mirror];
    end
  end

endmodule

@@ hw/rtl/fcb_state.sv @@
// Camera state registers: position with saturating moves, wrapping yaw, clamped pitch.
// Uses fcb_pkg for the command codes and the state struct.
module fcb_state #(
  parameter int PITCH_LIMIT = 15341
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  logic [1:0]               cmd,
  input  logic signed [31:0]       arg_x,
  input  logic signed [31:0]       arg_y,
  input  logic signed [31:0]       arg_z,
  input  logic signed [15:0]       yaw_arg,
  input  logic signed [15:0]       pitch_arg,
  output fcb_pkg::cam_state_t      st
);

  localparam logic signed [16:0] PitchLim = 17'(PITCH_LIMIT);

  fcb_pkg::cam_state_t st_next;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return s[31:0];
  endfunction

  function automatic logic signed [15:0] clamp(input logic signed [16:0] p);
    logic signed [16:0] c;
    c = p;
    if (p > PitchLim) c = PitchLim;
    if (p < -PitchLim) c = -PitchLim;
    return c[15:0];
  endfunction

  always_comb begin
    st_next = st;
    case (fcb_pkg::cmd_t'(cmd))
      fcb_pkg::CMD_SET_POS: begin
        st_next.pos_x = arg_x;
        st_next.pos_y = arg_y;
        st_next.pos_z = arg_z;
      end
      fcb_pkg::CMD_MOVE: begin
        st_next.pos_x = sat_add(st.pos_x, arg_x);
        st_next.pos_y = sat_add(st.pos_y, arg_y);
        st_next.pos_z = sat_add(st.pos_z, arg_z);
      end
      fcb_pkg::CMD_ROTATE: begin
        st_next.yaw   = st.yaw + yaw_arg;
        // The stored pitch is always within the limit, so one clamp suffices.
        st_next.pitch = clamp(17'(st.pitch) + 17'(pitch_arg));
      end
      fcb_pkg::CMD_SET_ANG: begin
        st_next.yaw   = yaw_arg;
        st_next.pitch = clamp(17'(pitch_arg));
      end
      default: st_next = st;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (load) begin
      st <= st_next;
    end
  end

endmodule

@@ hw/rtl/fcb_basis.sv @@
// Output stage: signs the table data by quadrant, forms the products, registers the result.
// Uses fcb_pkg for the stage and result structs.
module fcb_basis (
  input  logic                 clk,
  input  logic                 load,
  input  fcb_pkg::stage2_t     s2,
  input  logic [14:0]          yaw_lo,
  input  logic [14:0]          yaw_hi,
  input  logic [14:0]          pitch_lo,
  input  logic [14:0]          pitch_hi,
  output fcb_pkg::result_t     res
);

  function automatic logic signed [15:0] signed_mag(input logic [14:0] m, input logic neg);
    logic signed [15:0] v;
    v = $signed({1'b0, m});
    return neg ? -v : v;
  endfunction

  // Q1.14 product, rounded half up.
  function automatic logic signed [15:0] mul_q14(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [31:0] p;
    p = a * b;
    p = p + 32'sd8192;
    return p[29:14];
  endfunction

  logic signed [15:0] sy, cy, sp, cp;
  fcb_pkg::result_t   res_next;

  // Cosine sits one quadrant on, so it takes the mirrored entry and the shifted sign.
  assign sy = signed_mag(s2.yaw_q[0] ? yaw_hi : yaw_lo, s2.yaw_q[1]);
  assign cy = signed_mag(s2.yaw_q[0] ? yaw_lo : yaw_hi, s2.yaw_q[1] ^ s2.yaw_q[0]);
  assign sp = signed_mag(s2.pitch_q[0] ? pitch_hi : pitch_lo, s2.pitch_q[1]);
  assign cp = signed_mag(s2.pitch_q[0] ? pitch_lo : pitch_hi,
                         s2.pitch_q[1] ^ s2.pitch_q[0]);

  always_comb begin
    res_next.pos_x   = s2.pos_x;
    res_next.pos_y   = s2.pos_y;
    res_next.pos_z   = s2.pos_z;
    res_next.look_x  = mul_q14(cp, sy);
    res_next.look_y  = sp;
    res_next.look_z  = mul_q14(cp, cy);
    res_next.right_x = -cy;
    res_next.right_z = sy;
    res_next.up_x    = -mul_q14(sp, sy);
    res_next.up_y    = cp;
    res_next.up_z    = -mul_q14(sp, cy);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

endmodule

@@ hw/rtl/fps_camera_basis_update_unit.sv @@
// Camera basis unit: one command per word, one result word per command.
// Three registered stages: state update, sine table read, products and output register.
// Throughput: one command per cycle, held only by back-pressure on the output.
// Reset clears the position, yaw, pitch and all stage valid flags at once.
module fps_camera_basis_update_unit #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int PITCH_LIMIT     = 15341
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] arg_x,
  input  logic signed [31:0] arg_y,
  input  logic signed [31:0] arg_z,
  input  logic signed [15:0] yaw_arg,
  input  logic signed [15:0] pitch_arg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [15:0] look_x,
  output logic signed [15:0] look_y,
  output logic signed [15:0] look_z,
  output logic signed [15:0] right_x,
  output logic signed [15:0] right_z,
  output logic signed [15:0] up_x,
  output logic signed [15:0] up_y,
  output logic signed [15:0] up_z
);

  localparam logic signed [15:0] PitchLim = 16'(PITCH_LIMIT);

  logic v1, v2, v3;
  logic ready2, ready3;
  logic accept, adv2, adv3;
  logic [14:0] yaw_lo, yaw_hi, pitch_lo, pitch_hi;

  fcb_pkg::cam_state_t st;
  fcb_pkg::stage2_t    s2;
  fcb_pkg::result_t    res;

  assign ready3   = !v3 || out_ready;
  assign adv3     = v2 && ready3;
  assign ready2   = !v2 || ready3;
  assign adv2     = v1 && ready2;
  assign in_ready = !v1 || ready2;
  assign accept   = in_valid && in_ready;

  fcb_state #(
    .PITCH_LIMIT(PITCH_LIMIT)
  ) u_state (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .cmd      (cmd),
    .arg_x    (arg_x),
    .arg_y    (arg_y),
    .arg_z    (arg_z),
    .yaw_arg  (yaw_arg),
    .pitch_arg(pitch_arg),
    .st       (st)
  );

  fcb_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom_yaw (
    .clk  (clk),
    .en   (adv2),
    .angle(st.yaw),
    .lo   (yaw_lo),
    .hi   (yaw_hi)
  );

  fcb_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom_pitch (
    .clk  (clk),
    .en   (adv2),
    .angle(st.pitch),
    .lo   (pitch_lo),
    .hi   (pitch_hi)
  );

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2.pos_x   <= st.pos_x;
      s2.pos_y   <= st.pos_y;
      s2.pos_z   <= st.pos_z;
      s2.yaw_q   <= st.yaw[15:14];
      s2.pitch_q <= st.pitch[15:14];
    end
  end

  fcb_basis u_basis (
    .clk     (clk),
    .load    (adv3),
    .s2      (s2),
    .yaw_lo  (yaw_lo),
    .yaw_hi  (yaw_hi),
    .pitch_lo(pitch_lo),
    .pitch_hi(pitch_hi),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (accept) begin
        v1 <= 1'b1;
      end else if (adv2) begin
        v1 <= 1'b0;
      end
      if (adv2) begin
        v2 <= 1'b1;
      end else if (adv3) begin
        v2 <= 1'b0;
      end
      if (adv3) begin
        v3 <= 1'b1;
      end else if (out_ready) begin
        v3 <= 1'b0;
      end
    end
  end

  assign out_valid = v3;
  assign pos_x     = res.pos_x;
  assign pos_y     = res.pos_y;
  assign pos_z     = res.pos_z;
  assign look_x    = res.look_x;
  assign look_y    = res.look_y;
  assign look_z    = res.look_z;
  assign right_x   = res.right_x;
  assign right_z   = res.right_z;
  assign up_x      = res.up_x;
  assign up_y      = res.up_y;
  assign up_z      = res.up_z;

  // The stored pitch never leaves the clamp window.
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    (st.pitch <= PitchLim) && (st.pitch >= -PitchLim))
    else $error("pitch state outside clamp window");

  // A set-position command lands in the position registers unchanged.
  a_set_pos: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == fcb_pkg::CMD_SET_POS)) |=>
      (st.pos_x == $past(arg_x)) && (st.pos_y == $past(arg_y)) &&
      (st.pos_z == $past(arg_z)))
    else $error("set position not taken");

  // Pitch stays inside a quarter turn, so cos(pitch) is never negative.
  a_up_y_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !up_y[15])
    else $error("up_y negative");

endmodule
